/* hdl/morse_element_encoder_defines.svh */
// Assertion macros for the Morse element encoder.
// Included by the top level only; depends on nothing else.
`ifndef MORSE_ELEMENT_ENCODER_DEFINES_SVH
`define MORSE_ELEMENT_ENCODER_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define MEE_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define MEE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/mee_pkg.sv */
// Shared types, constants and the Morse code table for the element encoder.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package mee_pkg;

    // Result element codes
    typedef enum logic [1:0] {
        EL_DIT  = 2'd0,
        EL_DAH  = 2'd1,
        EL_WORD = 2'd2,
        EL_BAD  = 2'd3
    } mee_elem_t;

    // Character class decided by the front end
    typedef enum logic [1:0] {
        KIND_CODE = 2'd0,
        KIND_WORD = 2'd1,
        KIND_BAD  = 2'd2
    } mee_kind_t;

    // One queued character: class, element count and dah mask
    // (bit 0 is the first element sent, 1 = dah)
    typedef struct packed {
        mee_kind_t   kind;
        logic [2:0]  count;
        logic [4:0]  pattern;
    } mee_desc_t;

    localparam logic [7:0] DIT_LENGTH_RESET = 8'd60;

    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [7:0] ASCII_LOWER_A = 8'h61;
    localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;
    localparam logic [7:0] ASCII_ZERO    = 8'h30;
    localparam logic [7:0] ASCII_NINE    = 8'h39;
    localparam logic [7:0] ASCII_SPACE   = 8'h20;
    localparam logic [7:0] ASCII_CASE    = 8'h20;
    localparam logic [7:0] DIGIT_BASE    = 8'd26;

    // Morse table: a..z at 0..25, 0..9 at 26..35
    function automatic mee_desc_t mee_lookup(input logic [5:0] idx);
        mee_desc_t d;
        d.kind = KIND_CODE;
        case (idx)
            6'd0:  begin d.count = 3'd2; d.pattern = 5'b00010; end // a
            6'd1:  begin d.count = 3'd4; d.pattern = 5'b00001; end // b
            6'd2:  begin d.count = 3'd4; d.pattern = 5'b00101; end // c
            6'd3:  begin d.count = 3'd3; d.pattern = 5'b00001; end // d
            6'd4:  begin d.count = 3'd1; d.pattern = 5'b00000; end // e
            6'd5:  begin d.count = 3'd4; d.pattern = 5'b00100; end // f
            6'd6:  begin d.count = 3'd3; d.pattern = 5'b00011; end // g
            6'd7:  begin d.count = 3'd4; d.pattern = 5'b00000; end // h
            6'd8:  begin d.count = 3'd2; d.pattern = 5'b00000; end // i
            6'd9:  begin d.count = 3'd4; d.pattern = 5'b01110; end // j
            6'd10: begin d.count = 3'd3; d.pattern = 5'b00101; end // k
            6'd11: begin d.count = 3'd4; d.pattern = 5'b00010; end // l
            6'd12: begin d.count = 3'd2; d.pattern = 5'b00011; end // m
            6'd13: begin d.count = 3'd2; d.pattern = 5'b00001; end // n
            6'd14: begin d.count = 3'd3; d.pattern = 5'b00111; end // o
            6'd15: begin d.count = 3'd4; d.pattern = 5'b00110; end // p
            6'd16: begin d.count = 3'd4; d.pattern = 5'b01011; end // q
            6'd17: begin d.count = 3'd3; d.pattern = 5'b00010; end // r
            6'd18: begin d.count = 3'd3; d.pattern = 5'b00000; end // s
            6'd19: begin d.count = 3'd1; d.pattern = 5'b00001; end // t
            6'd20: begin d.count = 3'd3; d.pattern = 5'b00100; end // u
            6'd21: begin d.count = 3'd4; d.pattern = 5'b01000; end // v
            6'd22: begin d.count = 3'd3; d.pattern = 5'b00110; end // w
            6'd23: begin d.count = 3'd4; d.pattern = 5'b01001; end // x
            6'd24: begin d.count = 3'd4; d.pattern = 5'b01101; end // y
            6'd25: begin d.count = 3'd4; d.pattern = 5'b00011; end // z
            6'd26: begin d.count = 3'd5; d.pattern = 5'b11111; end // 0
            6'd27: begin d.count = 3'd5; d.pattern = 5'b11110; end // 1
            6'd28: begin d.count = 3'd5; d.pattern = 5'b11100; end // 2
            6'd29: begin d.count = 3'd5; d.pattern = 5'b11000; end // 3
            6'd30: begin d.count = 3'd5; d.pattern = 5'b10000; end // 4
            6'd31: begin d.count = 3'd5; d.pattern = 5'b00000; end // 5
            6'd32: begin d.count = 3'd5; d.pattern = 5'b00001; end // 6
            6'd33: begin d.count = 3'd5; d.pattern = 5'b00011; end // 7
            6'd34: begin d.count = 3'd5; d.pattern = 5'b00111; end // 8
            6'd35: begin d.count = 3'd5; d.pattern = 5'b01111; end // 9
            default: begin d.count = 3'd1; d.pattern = 5'b00000; end
        endcase
        return d;
    endfunction

endpackage

/* hdl/mee_front.sv */
// Front end: takes input characters, folds case and classifies them into
// queue descriptors. Depends on mee_pkg.
`timescale 1ns / 1ps

module mee_front (
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,     // [7:0] char_code
    input  logic                queue_full,
    output logic                queue_push,
    output mee_pkg::mee_desc_t  queue_desc
);

    logic [7:0] folded;

    // Accept whenever the queue has room
    assign s_tready   = !queue_full;
    assign queue_push = s_tvalid && !queue_full;

    // Case fold, then class and table lookup
    always_comb begin
        folded = s_tdata;
        if (s_tdata inside {[mee_pkg::ASCII_UPPER_A:mee_pkg::ASCII_UPPER_Z]}) begin
            folded = s_tdata | mee_pkg::ASCII_CASE;
        end

        queue_desc         = '0;
        queue_desc.kind    = mee_pkg::KIND_BAD;
        queue_desc.count   = 3'd1;
        if (folded inside {[mee_pkg::ASCII_LOWER_A:mee_pkg::ASCII_LOWER_Z]}) begin
            queue_desc = mee_pkg::mee_lookup(6'(folded - mee_pkg::ASCII_LOWER_A));
        end else if (folded inside {[mee_pkg::ASCII_ZERO:mee_pkg::ASCII_NINE]}) begin
            queue_desc = mee_pkg::mee_lookup(
                6'(folded - mee_pkg::ASCII_ZERO + mee_pkg::DIGIT_BASE));
        end else if (folded == mee_pkg::ASCII_SPACE) begin
            queue_desc.kind = mee_pkg::KIND_WORD;
        end
    end

endmodule

/* hdl/mee_queue.sv */
// Small descriptor queue between front end and element sequencer.
// Depends on mee_pkg for the descriptor type.
`timescale 1ns / 1ps

module mee_queue #(
    parameter int DEPTH = 2
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                wr_en,
    input  mee_pkg::mee_desc_t  wr_data,
    output logic                full,
    input  logic                rd_en,
    output mee_pkg::mee_desc_t  rd_data,
    output logic                empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mee_pkg::mee_desc_t mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   level_reg, level_next;

    assign full    = (level_reg == CNT_W'(DEPTH));
    assign empty   = (level_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    // Pointer wrap and fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (wr_en) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (rd_en) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (wr_en && !rd_en) begin
            level_next = level_reg + CNT_W'(1);
        end else if (!wr_en && rd_en) begin
            level_next = level_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* hdl/mee_back.sv */
// Element sequencer: walks the head descriptor one element per cycle unless
// the output stalls; drives the registered result channel. Depends on mee_pkg.
`timescale 1ns / 1ps

module mee_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [7:0]          dit_length,
    input  mee_pkg::mee_desc_t  head_desc,
    input  logic                head_empty,
    output logic                head_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata,   // [0] lamp, [11:1] lead_ms,
                                           // [21:12] tone_cycles, [31:22] gap_ms
    output logic [1:0]          m_tuser,   // [1:0] element
    output logic                m_tlast    // last
);

    logic        valid_reg, valid_next;
    logic [2:0]  idx_reg, idx_next;
    logic [1:0]  element_reg, element_next;
    logic        lamp_reg, lamp_next;
    logic [10:0] lead_reg, lead_next;
    logic [9:0]  tone_reg, tone_next;
    logic [9:0]  gap_reg, gap_next;
    logic        last_reg, last_next;

    logic        load;
    logic        dah;
    logic        fin;
    logic [9:0]  unit3;
    logic [10:0] unit7;

    // Unit multiples by shift, add and subtract
    assign unit3 = {1'b0, dit_length, 1'b0} + {2'b00, dit_length};
    assign unit7 = {dit_length, 3'b000} - {3'b000, dit_length};

    assign load = !head_empty && (!valid_reg || m_tready);
    assign dah  = head_desc.pattern[idx_reg];
    assign fin  = (head_desc.kind != mee_pkg::KIND_CODE) ||
                  (3'(idx_reg + 3'd1) == head_desc.count);
    assign head_pop = load && fin;

    // Next result word and element index
    always_comb begin
        valid_next   = valid_reg;
        idx_next     = idx_reg;
        element_next = element_reg;
        lamp_next    = lamp_reg;
        lead_next    = lead_reg;
        tone_next    = tone_reg;
        gap_next     = gap_reg;
        last_next    = last_reg;
        if (m_tready) begin
            valid_next = 1'b0;
        end
        if (load) begin
            valid_next = 1'b1;
            idx_next   = fin ? 3'd0 : 3'(idx_reg + 3'd1);
            last_next  = fin;
            case (head_desc.kind)
                mee_pkg::KIND_CODE: begin
                    element_next = dah ? mee_pkg::EL_DAH : mee_pkg::EL_DIT;
                    lamp_next    = dah;
                    lead_next    = dah ? {1'b0, unit3} : {3'b000, dit_length};
                    tone_next    = dah ? unit3 : {2'b00, dit_length};
                    gap_next     = unit3;
                end
                mee_pkg::KIND_WORD: begin
                    element_next = mee_pkg::EL_WORD;
                    lamp_next    = 1'b0;
                    lead_next    = unit7;
                    tone_next    = '0;
                    gap_next     = '0;
                end
                default: begin
                    element_next = mee_pkg::EL_BAD;
                    lamp_next    = 1'b0;
                    lead_next    = '0;
                    tone_next    = '0;
                    gap_next     = '0;
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    // Result payload, no reset
    always_ff @(posedge aclk) begin
        element_reg <= element_next;
        lamp_reg    <= lamp_next;
        lead_reg    <= lead_next;
        tone_reg    <= tone_next;
        gap_reg     <= gap_next;
        last_reg    <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {gap_reg, tone_reg, lead_reg, lamp_reg};
    assign m_tuser  = element_reg;
    assign m_tlast  = last_reg;

endmodule

/* hdl/morse_element_encoder.sv */
// Channel   | Dir | Word contents
// s_        | in  | tdata[7:0] char_code
// m_        | out | tdata lamp/lead_ms/tone_cycles/gap_ms, tuser element, tlast last
// cfg_w     | in  | wdata[7:0] dit_length
//
// A character is classified as it is accepted and written to the queue; the
// element sequencer then emits one result word per cycle unless the output stalls,
// 1 to 5 per character. The first result passes the queue and then the result
// register. The queue of QUEUE_DEPTH descriptors lets new characters enter while
// the sequencer is busy or the output is stalled; the input stalls only when the
// queue is full. Reset empties the queue and sets dit_length to 60.
//
// Top level of the Morse element encoder; depends on mee_pkg, mee_front,
// mee_queue, mee_back and morse_element_encoder_defines.svh.
`timescale 1ns / 1ps
`include "morse_element_encoder_defines.svh"

module morse_element_encoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] char_code
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [0] lamp, [11:1] lead_ms,
                                    // [21:12] tone_cycles, [31:22] gap_ms
    output logic [1:0]  m_tuser,    // [1:0] element
    output logic        m_tlast,    // last
    input  logic        cfg_wvalid,
    output logic        cfg_wready,
    input  logic [7:0]  cfg_wdata   // [7:0] dit_length
);

    logic [7:0]         dit_length_reg, dit_length_next;
    logic               queue_full;
    logic               queue_empty;
    logic               queue_push;
    logic               queue_pop;
    mee_pkg::mee_desc_t push_desc;
    mee_pkg::mee_desc_t head_desc;

    // Unit length register
    assign cfg_wready = 1'b1;
    assign dit_length_next = cfg_wvalid ? cfg_wdata : dit_length_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dit_length_reg <= mee_pkg::DIT_LENGTH_RESET;
        end else begin
            dit_length_reg <= dit_length_next;
        end
    end

    mee_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .queue_full (queue_full),
        .queue_push (queue_push),
        .queue_desc (push_desc)
    );

    mee_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (queue_push),
        .wr_data (push_desc),
        .full    (queue_full),
        .rd_en   (queue_pop),
        .rd_data (head_desc),
        .empty   (queue_empty)
    );

    mee_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .dit_length (dit_length_reg),
        .head_desc  (head_desc),
        .head_empty (queue_empty),
        .head_pop   (queue_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    // Checks
    `MEE_ASSERT_NOW(a_single_is_last, aclk, aresetn,
        m_tvalid && (m_tuser == mee_pkg::EL_WORD || m_tuser == mee_pkg::EL_BAD),
        m_tlast, "word gap or invalid result without last")
    `MEE_ASSERT_NOW(a_lamp_matches, aclk, aresetn, m_tvalid,
        m_tdata[0] == (m_tuser == mee_pkg::EL_DAH), "lamp does not match element")
    `MEE_ASSERT_NOW(a_tone_is_length, aclk, aresetn,
        m_tvalid && (m_tuser == mee_pkg::EL_DIT || m_tuser == mee_pkg::EL_DAH),
        {1'b0, m_tdata[21:12]} == m_tdata[11:1], "tone count differs from element length")
    `MEE_ASSERT_NEXT(a_pop_needs_entry, aclk, aresetn, queue_empty && !queue_push,
        !m_tvalid || $stable(m_tdata) || m_tready, "result changed with empty queue")

endmodule
